// File: design/ctsec_pkg.sv
// ctsec_pkg: widths, codes and shared types of the clock timestamp reader
// no dependencies
package ctsec_pkg;

    localparam int MAX_HOUR_DIGITS = 6;

    localparam int CHAR_W   = 21;
    localparam int TOTAL_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FIRST_W  = $clog2(10 ** MAX_HOUR_DIGITS);
    localparam int MS_W     = 7;
    localparam int FDIG_W   = $clog2(MAX_HOUR_DIGITS + 2);

    localparam logic [CHAR_W-1:0] SEP_RESET  = CHAR_W'(58);
    localparam logic [CHAR_W-1:0] CODE_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CODE_NINE  = CHAR_W'(57);
    localparam logic [CHAR_W-1:0] CODE_SPACE = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CODE_TAB   = CHAR_W'(9);
    localparam logic [CHAR_W-1:0] CODE_CR    = CHAR_W'(13);

    localparam logic [FDIG_W-1:0] FDIG_MAX  = FDIG_W'(MAX_HOUR_DIGITS);
    localparam logic [FDIG_W-1:0] FDIG_SAT  = FDIG_W'(MAX_HOUR_DIGITS + 1);
    localparam logic [FDIG_W-1:0] FDIG_TWO  = FDIG_W'(2);

    localparam logic [TOTAL_W-1:0] SECS_PER_HOUR = TOTAL_W'(3600);
    localparam logic [TOTAL_W-1:0] SECS_PER_MIN  = TOTAL_W'(60);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FORMAT    = 2'd1,
        ST_NO_TERM   = 2'd2,
        ST_HOUR_LONG = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic               hms;
        logic [FIRST_W-1:0] first;
        logic [MS_W-1:0]    middle;
        logic [MS_W-1:0]    last;
    } t_snap;

endpackage

// File: design/ctsec_scan.sv
// ctsec_scan: per-line character scanner, field accumulators and status decode
// depends on ctsec_pkg
module ctsec_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [ctsec_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                          i_end_of_line,
    input  logic [ctsec_pkg::CHAR_W-1:0]  i_sep_code,
    output ctsec_pkg::t_snap              o_snap
);
    import ctsec_pkg::*;

    logic [FIRST_W-1:0] r_first,  n_first;
    logic [MS_W-1:0]    r_middle, n_middle;
    logic [MS_W-1:0]    r_last,   n_last;
    logic [1:0]         r_seps,   n_seps;
    logic [1:0]         r_fdig,   n_fdig;
    logic [FDIG_W-1:0]  r_hdig,   n_hdig;
    logic               r_term,   n_term;
    logic               r_fault,  n_fault;

    logic       is_space;
    logic       is_digit;
    logic [3:0] digit;

    assign is_space = (i_char_code == CODE_SPACE) ||
                      (i_char_code >= CODE_TAB && i_char_code <= CODE_CR);
    assign is_digit = (i_char_code >= CODE_ZERO) && (i_char_code <= CODE_NINE);
    assign digit    = i_char_code[3:0];

    always_comb begin
        n_first  = r_first;
        n_middle = r_middle;
        n_last   = r_last;
        n_seps   = r_seps;
        n_fdig   = r_fdig;
        n_hdig   = r_hdig;
        n_term   = r_term;
        n_fault  = r_fault;
        if (!r_term) begin
            if (is_space) begin
                n_term = 1'b1;
            end else if (i_char_code == i_sep_code) begin
                if (r_seps != 2'd3) begin
                    n_seps = r_seps + 2'd1;
                end
                n_fdig = 2'd0;
            end else if (!is_digit) begin
                n_fault = 1'b1;
            end else if (r_seps == 2'd0) begin
                if (r_hdig < FDIG_MAX) begin
                    n_first = FIRST_W'((FIRST_W + 4)'(r_first) * (FIRST_W + 4)'(10)
                                       + (FIRST_W + 4)'(digit));
                    n_hdig  = r_hdig + FDIG_W'(1);
                end else begin
                    n_hdig = FDIG_SAT;
                end
            end else if (r_fdig >= 2'd2 || r_seps == 2'd3) begin
                n_fault = 1'b1;
                if (r_fdig != 2'd3) begin
                    n_fdig = r_fdig + 2'd1;
                end
            end else begin
                if (r_seps == 2'd1) begin
                    n_middle = MS_W'(r_middle * MS_W'(10) + MS_W'(digit));
                end else begin
                    n_last = MS_W'(r_last * MS_W'(10) + MS_W'(digit));
                end
                n_fdig = r_fdig + 2'd1;
            end
        end
    end

    // status of the line as it stands after this character
    always_comb begin
        o_snap.hms    = (n_seps == 2'd2);
        o_snap.first  = n_first;
        o_snap.middle = n_middle;
        o_snap.last   = n_last;
        if (n_fault || n_seps == 2'd0 || n_seps == 2'd3 ||
            (n_seps == 2'd1 && n_hdig > FDIG_TWO)) begin
            o_snap.status = ST_FORMAT;
        end else if (n_seps == 2'd2 && n_hdig > FDIG_MAX) begin
            o_snap.status = ST_HOUR_LONG;
        end else if (!n_term) begin
            o_snap.status = ST_NO_TERM;
        end else begin
            o_snap.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end_of_line)) begin
            r_first  <= '0;
            r_middle <= '0;
            r_last   <= '0;
            r_seps   <= '0;
            r_fdig   <= '0;
            r_hdig   <= '0;
            r_term   <= 1'b0;
            r_fault  <= 1'b0;
        end else if (i_take) begin
            r_first  <= n_first;
            r_middle <= n_middle;
            r_last   <= n_last;
            r_seps   <= n_seps;
            r_fdig   <= n_fdig;
            r_hdig   <= n_hdig;
            r_term   <= n_term;
            r_fault  <= n_fault;
        end
    end

endmodule

// File: design/clock_timestamp_to_seconds.sv
// clock_timestamp_to_seconds: reads a leading H:MM:SS or MM:SS stamp from a character stream
// depends on ctsec_pkg and ctsec_scan
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  input    | i_in_valid / o_in_stall    | i_char_code, i_end_of_line
//  output   | o_out_valid / i_out_stall  | o_total_seconds, o_status
//  config   | i_cfg_we                   | i_cfg_data (separator code)
//
//  one character per cycle while o_in_stall is low; the line state updates on each input transfer
//  after the end-of-line transfer the result passes the snapshot register, then the sum register
//  the sum stage is the hours * 3600 and minutes * 60 constant products
//  output stall backs up through two registers before o_in_stall rises
//  synchronous active-low reset clears line state and both valid flags, separator back to colon
module clock_timestamp_to_seconds (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ctsec_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                            i_end_of_line,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ctsec_pkg::TOTAL_W-1:0]   o_total_seconds,
    output logic [ctsec_pkg::STATUS_W-1:0]  o_status,
    input  logic                            i_cfg_we,
    input  logic [ctsec_pkg::CHAR_W-1:0]    i_cfg_data
);
    import ctsec_pkg::*;

    logic [CHAR_W-1:0]  r_sep;
    t_snap              scan_snap;
    t_snap              r_snap;
    logic               r_snap_valid;
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_total, n_total;
    t_status            r_status;

    logic take;
    logic out_free;
    logic snap_move;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign snap_move  = r_snap_valid && out_free;
    assign o_in_stall = r_snap_valid && !out_free;
    assign take       = i_in_valid && !o_in_stall;

    ctsec_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_char_code   (i_char_code),
        .i_end_of_line (i_end_of_line),
        .i_sep_code    (r_sep),
        .o_snap        (scan_snap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (i_cfg_we) begin
            r_sep <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (take && i_end_of_line) begin
            r_snap_valid <= 1'b1;
        end else if (snap_move) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_end_of_line) begin
            r_snap <= scan_snap;
        end
    end

    always_comb begin
        if (r_snap.status != ST_OK) begin
            n_total = '0;
        end else if (r_snap.hms) begin
            n_total = TOTAL_W'(r_snap.first) * SECS_PER_HOUR
                    + TOTAL_W'(r_snap.middle) * SECS_PER_MIN
                    + TOTAL_W'(r_snap.last);
        end else begin
            n_total = TOTAL_W'(r_snap.first) * SECS_PER_MIN + TOTAL_W'(r_snap.middle);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_move) begin
            r_total  <= n_total;
            r_status <= r_snap.status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_total_seconds = r_total;
    assign o_status        = r_status;

endmodule

// File: design/ctsec_check.sv
// ctsec_check: port-level assertions for clock_timestamp_to_seconds, bound to the top level
// depends on ctsec_pkg
module ctsec_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [ctsec_pkg::TOTAL_W-1:0]   o_total_seconds,
    input logic [ctsec_pkg::STATUS_W-1:0]  o_status
);
    import ctsec_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_fail_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_total_seconds == '0))
        else $error("non-zero total on failed line");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with the output side free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_total_seconds) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind clock_timestamp_to_seconds ctsec_check u_ctsec_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_total_seconds (o_total_seconds),
    .o_status        (o_status)
);

// File: test/clock_timestamp_to_seconds_test.sv
`timescale 1ns / 100ps
// clock_timestamp_to_seconds_test: drives character lines into the timestamp reader
// and checks every total and status against a predictor held in a small scoreboard class
// depends on ctsec_pkg and clock_timestamp_to_seconds
import ctsec_pkg::*;

class stamp_checker;
    typedef struct {
        logic [TOTAL_W-1:0] secs;
        t_status            status;
    } t_stamp;

    logic [CHAR_W-1:0] sep_code;
    int unsigned       first_val, mid_val, last_val;
    int unsigned       sep_count, field_cnt, first_cnt;
    bit                term_seen, fmt_fault;
    t_stamp            expected_totals[$];
    int                mismatches;

    function new();
        sep_code   = SEP_RESET;
        mismatches = 0;
        clear_line();
    endfunction

    function void clear_line();
        first_val = 0;
        mid_val   = 0;
        last_val  = 0;
        sep_count = 0;
        field_cnt = 0;
        first_cnt = 0;
        term_seen = 1'b0;
        fmt_fault = 1'b0;
    endfunction

    function void set_separator(logic [CHAR_W-1:0] code);
        sep_code = code;
    endfunction

    function int pending();
        return expected_totals.size();
    endfunction

    // one accepted transfer on the input channel
    function void note_char(logic [CHAR_W-1:0] c, bit eol);
        int unsigned     d;
        longint unsigned sum;
        t_stamp          e;
        if (!term_seen) begin
            if (c == CODE_SPACE || (c >= CODE_TAB && c <= CODE_CR)) begin
                term_seen = 1'b1;
            end else if (c == sep_code) begin
                if (sep_count < 3) sep_count++;
                field_cnt = 0;
            end else if (c < CODE_ZERO || c > CODE_NINE) begin
                fmt_fault = 1'b1;
            end else begin
                d = c - CODE_ZERO;
                if (sep_count == 0) begin
                    if (first_cnt < MAX_HOUR_DIGITS) begin
                        first_val = first_val * 10 + d;
                        first_cnt++;
                    end else begin
                        first_cnt = MAX_HOUR_DIGITS + 1;
                    end
                end else if (field_cnt >= 2 || sep_count >= 3) begin
                    fmt_fault = 1'b1;
                    if (field_cnt < 3) field_cnt++;
                end else begin
                    if (sep_count == 1) mid_val = mid_val * 10 + d;
                    else last_val = last_val * 10 + d;
                    field_cnt++;
                end
            end
        end
        if (!eol) return;
        e.secs = '0;
        if (fmt_fault || sep_count == 0 || sep_count == 3 || (sep_count == 1 && first_cnt > 2)) begin
            e.status = ST_FORMAT;
        end else if (sep_count == 2 && first_cnt > MAX_HOUR_DIGITS) begin
            e.status = ST_HOUR_LONG;
        end else if (!term_seen) begin
            e.status = ST_NO_TERM;
        end else begin
            e.status = ST_OK;
            if (sep_count == 2) sum = 64'(first_val) * 3600 + 64'(mid_val) * 60 + last_val;
            else sum = 64'(first_val) * 60 + mid_val;
            e.secs = sum[TOTAL_W-1:0];
        end
        expected_totals.push_back(e);
        clear_line();
    endfunction

    // one accepted transfer on the output channel
    function void check_total(logic [TOTAL_W-1:0] secs, logic [STATUS_W-1:0] status);
        t_stamp e;
        if (expected_totals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %0d seconds, status %0d", secs, status);
            return;
        end
        e = expected_totals.pop_front();
        if (secs !== e.secs || status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %0d seconds status %0d, got %0d seconds status %0d",
                         e.secs, e.status, secs, status);
        end
    endfunction
endclass

module clock_timestamp_to_seconds_test;

    localparam int                CLK_HALF        = 5;
    localparam int                CYCLE_LIMIT     = 500000;
    localparam int                ITEMS_PER_PHASE = 170;
    localparam logic [CHAR_W-1:0] CODE_MAX        = CHAR_W'(21'h10FFFF);

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_stall;
    logic [CHAR_W-1:0]   i_char_code     = '0;
    logic                i_end_of_line   = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall     = 1'b0;
    logic [TOTAL_W-1:0]  o_total_seconds;
    logic [STATUS_W-1:0] o_status;
    logic                i_cfg_we        = 1'b0;
    logic [CHAR_W-1:0]   i_cfg_data      = '0;

    stamp_checker      sb;
    logic [CHAR_W-1:0] line_chars[$];
    logic [CHAR_W-1:0] cur_sep = SEP_RESET;
    logic [CHAR_W-1:0] sep_plan[7] = '{CODE_MAX, 21'd0, 21'd53, 21'd32, 21'h0F0000, 21'd47, 21'd58};
    bit                idle_on = 1'b1;
    int                stall_left = 0;
    int                cycle_count = 0;

    clock_timestamp_to_seconds i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_code     (i_char_code),
        .i_end_of_line   (i_end_of_line),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_total_seconds (o_total_seconds),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [CHAR_W-1:0] pick_space();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? CODE_SPACE : CHAR_W'(r);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 4))
            0: return CHAR_W'(CODE_ZERO + $urandom_range(0, 9));
            1: return cur_sep;
            2: return pick_space();
            3: return CHAR_W'($urandom_range(0, 127));
            default: return CHAR_W'($urandom_range(0, CODE_MAX));
        endcase
    endfunction

    function automatic void add_field(int n);
        bit nines;
        nines = ($urandom_range(0, 7) == 0);
        repeat (n) line_chars.push_back(nines ? CODE_NINE : CHAR_W'(CODE_ZERO + $urandom_range(0, 9)));
    endfunction

    // mostly well-formed stamps with random content, some broken, some noise
    function automatic void fill_random_line();
        int kind;
        int pos;
        kind = $urandom_range(0, 9);
        line_chars.delete();
        if (kind >= 8) begin
            repeat ($urandom_range(1, 8)) line_chars.push_back(pick_char());
            return;
        end
        if ($urandom_range(0, 1) == 1) begin
            add_field(($urandom_range(0, 11) == 0) ?
                      $urandom_range(MAX_HOUR_DIGITS - 1, MAX_HOUR_DIGITS + 2) : $urandom_range(0, 2));
            line_chars.push_back(cur_sep);
        end
        add_field(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2));
        line_chars.push_back(cur_sep);
        add_field(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2));
        if (kind == 7) begin
            pos = $urandom_range(0, line_chars.size());
            line_chars.insert(pos, pick_char());
        end
        if ($urandom_range(0, 7) != 0) begin
            line_chars.push_back(pick_space());
            repeat ($urandom_range(0, 3)) line_chars.push_back(pick_char());
        end
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input bit eol);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_char_code   <= c;
        i_end_of_line <= eol;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_char(c, eol);
    endtask

    task automatic send_line();
        foreach (line_chars[k]) send_char(line_chars[k], k == line_chars.size() - 1);
    endtask

    task automatic send_text(input string s);
        line_chars.delete();
        for (int i = 0; i < s.len(); i++) line_chars.push_back(CHAR_W'(s[i]));
        send_line();
    endtask

    // output side: sample transfers, then random stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_total(o_total_seconds, o_status);
        if (stall_left > 0) stall_left--;
        else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
        i_out_stall <= (stall_left > 0);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("clock_timestamp_to_seconds regression: fail");
        $finish;
    end

    initial begin
        int phase_items;
        bit last_phase;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("1:2:3 ");
        send_text("::\015");
        send_text("5:7");
        line_chars = '{CODE_MAX};
        send_line();
        send_text("1234567::");
        send_text("99:99 x");

        foreach (sep_plan[p]) begin
            // separator changes only once the reader has drained
            i_in_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_data <= sep_plan[p];
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            cur_sep = sep_plan[p];
            sb.set_separator(sep_plan[p]);
            last_phase  = (p == $size(sep_plan) - 1);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                idle_on = !last_phase && ($urandom_range(0, 3) != 0);
                fill_random_line();
                send_line();
                phase_items += line_chars.size();
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("clock_timestamp_to_seconds regression: pass");
        end else begin
            $display("clock_timestamp_to_seconds regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
design/ctsec_pkg.sv
design/ctsec_scan.sv
design/clock_timestamp_to_seconds.sv
design/ctsec_check.sv
test/clock_timestamp_to_seconds_test.sv
